[rtl/core/pbag_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the padded blit address generator
// no dependencies

package pbag_pkg;

  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned CntW    = $clog2(MaxDim);
  localparam int unsigned DimW    = 13;
  localparam int unsigned PlaceW  = 12;
  localparam int unsigned CoordW  = ((CntW > DimW) ? CntW : DimW) + 1;
  localparam int unsigned PixW    = 32;
  localparam int unsigned IdxW    = 24;
  localparam int unsigned ProdW   = CoordW + DimW;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegDstWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDstHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPlaceX    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPlaceY    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 3'd5;

  // write slots of one pixel, in issue order
  localparam int unsigned NumWr   = 9;
  localparam int unsigned WrMain  = 0;
  localparam int unsigned WrTop   = 1;
  localparam int unsigned WrBot   = 2;
  localparam int unsigned WrLeft  = 3;
  localparam int unsigned WrRight = 4;
  localparam int unsigned WrTl    = 5;
  localparam int unsigned WrTr    = 6;
  localparam int unsigned WrBl    = 7;
  localparam int unsigned WrBr    = 8;

  localparam logic [NumWr-1:0] ColLeftSel =
      (NumWr'(1) << WrLeft) | (NumWr'(1) << WrTl) | (NumWr'(1) << WrBl);
  localparam logic [NumWr-1:0] ColRightSel =
      (NumWr'(1) << WrRight) | (NumWr'(1) << WrTr) | (NumWr'(1) << WrBr);
  localparam logic [NumWr-1:0] RowTopSel =
      (NumWr'(1) << WrTop) | (NumWr'(1) << WrTl) | (NumWr'(1) << WrTr);
  localparam logic [NumWr-1:0] RowBotSel =
      (NumWr'(1) << WrBot) | (NumWr'(1) << WrBl) | (NumWr'(1) << WrBr);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [DimW-1:0]   dst_width;
    logic [DimW-1:0]   dst_height;
    logic [PlaceW-1:0] place_x;
    logic [PlaceW-1:0] place_y;
    logic [DimW-1:0]   src_width;
    logic [DimW-1:0]   src_height;
  } pbag_cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] left_col;
    logic [CoordW-1:0] right_col;
    logic [CoordW-1:0] top_row;
    logic [CoordW-1:0] bot_row;
    logic [DimW-1:0]   dst_width;
    logic [DimW-1:0]   dst_height;
  } pbag_geom_t;

  typedef struct packed {
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [NumWr-1:0]  mask;
    logic              fit;
    logic              done;
  } pbag_entry_t;

  function automatic logic [DimW-1:0] clamp_size(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > MaxDim) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

[rtl/core/padded_blit_address_gen_core.sv]
`timescale 1ns / 1ps
// top level of the padded blit address generator: configuration registers,
// front end, transaction queue and back end; depends on pbag_pkg and submodules
//
// usage:
//   source pixels enter in raster order on in_valid_i / in_ready_o / pixel_i.
//   each pixel yields one to nine write transactions on out_valid_o /
//   out_ready_i: main write, then top, bottom, left, right padding and the
//   four corners where they apply; last_o marks the final one of a pixel and
//   image_done_o flags every transaction of the final source pixel.
//   configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle, one register per cycle.
//   an accepted pixel goes into the queue; each transaction then passes the
//   stage-one and output registers. throughput: one transaction per cycle
//   while out_ready_i holds, set by the back end issuing one write slot per
//   cycle, so interior pixels sustain one pixel per cycle; edge pixels take longer.
//   a four-entry queue decouples the input from the back end: in_ready_o
//   drops only when the queue is full, which happens when the receiver
//   stalls or edge pixels back up. reset empties the queue and pipeline,
//   returns the source position to the top-left pixel and loads register
//   defaults (sizes 1, placement 0).

module padded_blit_address_gen_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pbag_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbag_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [23:0]                  dest_index_o,
  output logic [31:0]                  color_o,
  output logic                         write_enable_o,
  output logic                         fit_error_o,
  output logic                         last_o,
  output logic                         image_done_o
);
  import pbag_pkg::*;

  pbag_cfg_t   cfg_q, cfg_d;
  pbag_geom_t  geom;
  pbag_entry_t entry, head;
  logic        accept, q_full, q_valid, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegDstWidth:  cfg_d.dst_width  = cfg_data_i[DimW-1:0];
        RegDstHeight: cfg_d.dst_height = cfg_data_i[DimW-1:0];
        RegPlaceX:    cfg_d.place_x    = cfg_data_i[PlaceW-1:0];
        RegPlaceY:    cfg_d.place_y    = cfg_data_i[PlaceW-1:0];
        RegSrcWidth:  cfg_d.src_width  = cfg_data_i[DimW-1:0];
        RegSrcHeight: cfg_d.src_height = cfg_data_i[DimW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dst_width  <= DimW'(1);
      cfg_q.dst_height <= DimW'(1);
      cfg_q.place_x    <= '0;
      cfg_q.place_y    <= '0;
      cfg_q.src_width  <= DimW'(1);
      cfg_q.src_height <= DimW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  pbag_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .pixel_i  (pixel_i),
    .entry_o  (entry),
    .geom_o   (geom)
  );

  pbag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  pbag_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .head_valid_i   (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_index_o   (dest_index_o),
    .color_o        (color_o),
    .write_enable_o (write_enable_o),
    .fit_error_o    (fit_error_o),
    .last_o         (last_o),
    .image_done_o   (image_done_o)
  );

endmodule

[rtl/core/pbag_front.sv]
`timescale 1ns / 1ps
// front end: source position counters and per-pixel write classification
// depends on pbag_pkg

module pbag_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbag_pkg::pbag_cfg_t  cfg_i,
  input  logic                 accept_i,
  input  logic [31:0]          pixel_i,
  output pbag_pkg::pbag_entry_t entry_o,
  output pbag_pkg::pbag_geom_t geom_o
);
  import pbag_pkg::*;

  logic [CntW-1:0]   col_q, col_d;
  logic [CntW-1:0]   row_q, row_d;
  logic [DimW-1:0]   sw, sh;
  logic [CoordW-1:0] end_x, end_y;
  logic              fit, top, left, right, bottom;
  logic              first_col, first_row, last_col, last_row;
  logic [NumWr-1:0]  mask;

  assign sw    = clamp_size(cfg_i.src_width);
  assign sh    = clamp_size(cfg_i.src_height);
  assign end_x = CoordW'(cfg_i.place_x) + CoordW'(sw);
  assign end_y = CoordW'(cfg_i.place_y) + CoordW'(sh);

  assign fit    = (end_x > CoordW'(cfg_i.dst_width)) || (end_y > CoordW'(cfg_i.dst_height));
  assign top    = cfg_i.place_y != '0;
  assign left   = cfg_i.place_x != '0;
  assign right  = end_x < CoordW'(cfg_i.dst_width);
  assign bottom = end_y < CoordW'(cfg_i.dst_height);

  assign first_col = col_q == '0;
  assign first_row = row_q == '0;
  assign last_col  = (CoordW'(col_q) + CoordW'(1)) >= CoordW'(sw);
  assign last_row  = (CoordW'(row_q) + CoordW'(1)) >= CoordW'(sh);

  always_comb begin
    mask          = '0;
    mask[WrMain]  = 1'b1;
    mask[WrTop]   = top && first_row;
    mask[WrBot]   = bottom && last_row;
    mask[WrLeft]  = left && first_col;
    mask[WrRight] = right && last_col;
    mask[WrTl]    = top && left && first_row && first_col;
    mask[WrTr]    = top && right && first_row && last_col;
    mask[WrBl]    = bottom && left && last_row && first_col;
    mask[WrBr]    = bottom && right && last_row && last_col;
  end

  always_comb begin
    entry_o.pixel = pixel_i;
    entry_o.col   = CoordW'(cfg_i.place_x) + CoordW'(col_q);
    entry_o.row   = CoordW'(cfg_i.place_y) + CoordW'(row_q);
    entry_o.mask  = mask;
    entry_o.fit   = fit;
    entry_o.done  = last_col && last_row;
  end

  always_comb begin
    geom_o.left_col   = CoordW'(cfg_i.place_x) - CoordW'(1);
    geom_o.right_col  = end_x;
    geom_o.top_row    = CoordW'(cfg_i.place_y) - CoordW'(1);
    geom_o.bot_row    = end_y;
    geom_o.dst_width  = cfg_i.dst_width;
    geom_o.dst_height = cfg_i.dst_height;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept_i && entry_o.done) |=> (col_q == '0 && row_q == '0))
    else $error("counters not cleared after final pixel");

endmodule

[rtl/core/pbag_queue.sv]
`timescale 1ns / 1ps
// short transaction queue between the front end and the write issue back end
// depends on pbag_pkg

module pbag_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pbag_pkg::pbag_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output pbag_pkg::pbag_entry_t head_o
);
  import pbag_pkg::*;

  pbag_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o  = count_q == QCntW'(QDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(push_i && full_o) && !(pop_i && !valid_o))
    else $error("queue overflow or underflow");

endmodule

[rtl/core/pbag_back.sv]
`timescale 1ns / 1ps
// back end: walks the write slots of the head transaction, one write per cycle
// unless the output stalls, then forms the linear index into the output register; depends on pbag_pkg

module pbag_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbag_pkg::pbag_geom_t  geom_i,
  input  logic                  head_valid_i,
  input  pbag_pkg::pbag_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [23:0]           dest_index_o,
  output logic [31:0]           color_o,
  output logic                  write_enable_o,
  output logic                  fit_error_o,
  output logic                  last_o,
  output logic                  image_done_o
);
  import pbag_pkg::*;

  logic              started_q, started_d;
  logic [NumWr-1:0]  rem_q, rem_d;
  logic [NumWr-1:0]  remaining, pick, rest;
  logic              issue, s1_ready, s2_load;
  logic [CoordW-1:0] sel_col, sel_row;

  logic              s1_valid_q, s1_valid_d;
  logic [CoordW-1:0] s1_col_q, s1_row_q;
  logic              s1_we_q, s1_fit_q, s1_last_q, s1_done_q;
  logic [PixW-1:0]   s1_pixel_q;

  logic              o_valid_q, o_valid_d;
  logic [IdxW-1:0]   o_index_q;
  logic [PixW-1:0]   o_pixel_q;
  logic              o_we_q, o_fit_q, o_last_q, o_done_q;
  logic [ProdW-1:0]  lin;

  assign remaining = started_q ? rem_q : head_i.mask;
  assign pick      = remaining & (~remaining + NumWr'(1));
  assign rest      = remaining & ~pick;

  assign s2_load  = !o_valid_q || out_ready_i;
  assign s1_ready = !s1_valid_q || s2_load;
  assign issue    = head_valid_i && s1_ready;
  assign pop_o    = issue && (rest == '0);

  always_comb begin
    if ((pick & ColLeftSel) != '0) begin
      sel_col = geom_i.left_col;
    end else if ((pick & ColRightSel) != '0) begin
      sel_col = geom_i.right_col;
    end else begin
      sel_col = head_i.col;
    end
    if ((pick & RowTopSel) != '0) begin
      sel_row = geom_i.top_row;
    end else if ((pick & RowBotSel) != '0) begin
      sel_row = geom_i.bot_row;
    end else begin
      sel_row = head_i.row;
    end
  end

  always_comb begin
    started_d = started_q;
    rem_d     = rem_q;
    if (issue) begin
      started_d = rest != '0;
      rem_d     = rest;
    end
  end

  assign s1_valid_d = issue || (s1_valid_q && !s2_load);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_col_q   <= sel_col;
      s1_row_q   <= sel_row;
      s1_we_q    <= (sel_col < CoordW'(geom_i.dst_width)) &&
                    (sel_row < CoordW'(geom_i.dst_height));
      s1_pixel_q <= head_i.pixel;
      s1_fit_q   <= head_i.fit;
      s1_last_q  <= rest == '0;
      s1_done_q  <= head_i.done;
    end
  end

  assign lin = ProdW'(s1_row_q) * ProdW'(geom_i.dst_width) + ProdW'(s1_col_q);

  assign o_valid_d = (s1_valid_q && s2_load) || (o_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_load) begin
      o_index_q <= s1_we_q ? lin[IdxW-1:0] : '0;
      o_pixel_q <= s1_pixel_q;
      o_we_q    <= s1_we_q;
      o_fit_q   <= s1_fit_q;
      o_last_q  <= s1_last_q;
      o_done_q  <= s1_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      rem_q      <= '0;
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      started_q  <= started_d;
      rem_q      <= rem_d;
      s1_valid_q <= s1_valid_d;
      o_valid_q  <= o_valid_d;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign dest_index_o   = o_index_q;
  assign color_o        = o_pixel_q;
  assign write_enable_o = o_we_q;
  assign fit_error_o    = o_fit_q;
  assign last_o         = o_last_q;
  assign image_done_o   = o_done_q;

  a_main_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (head_valid_i && !started_q) |-> head_i.mask[WrMain])
    else $error("fresh transaction without main write");

  a_partial_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
      started_q |-> head_valid_i)
    else $error("partly issued transaction left the queue");

  a_suppressed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !write_enable_o) |-> (dest_index_o == '0))
    else $error("suppressed write with nonzero index");

endmodule

[tb/padded_blit_address_gen_core_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for padded_blit_address_gen_core: directed and random images,
// an in-line prediction of every write transaction, random idling on both channels
// depends on pbag_pkg and the core

module padded_blit_address_gen_core_tb;
  import pbag_pkg::*;

  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumItems    = 280;

  typedef struct packed {
    logic [IdxW-1:0] dest_index;
    logic [PixW-1:0] color;
    logic            write_enable;
    logic            fit_error;
    logic            last;
    logic            image_done;
  } blit_write_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic [PixW-1:0]     pixel     = '0;
  logic                out_ready = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [IdxW-1:0]     dest_index_o;
  logic [PixW-1:0]     color_o;
  logic                write_enable_o;
  logic                fit_error_o;
  logic                last_o;
  logic                image_done_o;

  // predicted configuration and source position
  logic [DimW-1:0]   dst_w_m = DimW'(1);
  logic [DimW-1:0]   dst_h_m = DimW'(1);
  logic [PlaceW-1:0] plc_x_m = '0;
  logic [PlaceW-1:0] plc_y_m = '0;
  logic [DimW-1:0]   src_w_m = DimW'(1);
  logic [DimW-1:0]   src_h_m = DimW'(1);
  logic [CntW-1:0]   col_pos = '0;
  logic [CntW-1:0]   row_pos = '0;

  logic [PixW-1:0] pixel_q[$];
  blit_write_t     exp_writes_q[$];
  blit_write_t     got_w;
  blit_write_t     want_w;
  int unsigned     err_cnt     = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     sent_cnt    = 0;
  bit              calm        = 1'b0;

  padded_blit_address_gen_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .dest_index_o  (dest_index_o),
    .color_o       (color_o),
    .write_enable_o(write_enable_o),
    .fit_error_o   (fit_error_o),
    .last_o        (last_o),
    .image_done_o  (image_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 19);
  endfunction

  function automatic void push_write(input int unsigned col, input int unsigned row,
                                     input logic [PixW-1:0] color, input bit fit,
                                     input bit done);
    blit_write_t     w;
    longint unsigned lin;
    w.write_enable = (col < dst_w_m) && (row < dst_h_m);
    lin = row;
    lin = lin * dst_w_m + col;
    w.dest_index = w.write_enable ? lin[IdxW-1:0] : '0;
    w.color      = color;
    w.fit_error  = fit;
    w.last       = 1'b0;
    w.image_done = done;
    exp_writes_q.push_back(w);
  endfunction

  function automatic void predict_pixel(input logic [PixW-1:0] pix);
    int unsigned sw, sh, c, r, end_x, end_y, col, row;
    bit          fit, top, left, right, bottom, fc, fr, lc, lr, done;
    sw = (src_w_m == 0) ? 1 : ((src_w_m > MaxDim) ? MaxDim : src_w_m);
    sh = (src_h_m == 0) ? 1 : ((src_h_m > MaxDim) ? MaxDim : src_h_m);
    c = col_pos;
    r = row_pos;
    end_x = plc_x_m + sw;
    end_y = plc_y_m + sh;
    fit = (end_x > dst_w_m) || (end_y > dst_h_m);
    top = plc_y_m != 0;
    left = plc_x_m != 0;
    right = end_x < dst_w_m;
    bottom = end_y < dst_h_m;
    fc = c == 0;
    fr = r == 0;
    lc = c + 1 >= sw;
    lr = r + 1 >= sh;
    done = lc && lr;
    col = plc_x_m + c;
    row = plc_y_m + r;
    push_write(col, row, pix, fit, done);
    if (top && fr) push_write(col, plc_y_m - 1, pix, fit, done);
    if (bottom && lr) push_write(col, end_y, pix, fit, done);
    if (left && fc) push_write(plc_x_m - 1, row, pix, fit, done);
    if (right && lc) push_write(end_x, row, pix, fit, done);
    if (top && left && fr && fc) push_write(plc_x_m - 1, plc_y_m - 1, pix, fit, done);
    if (top && right && fr && lc) push_write(end_x, plc_y_m - 1, pix, fit, done);
    if (bottom && left && lr && fc) push_write(plc_x_m - 1, end_y, pix, fit, done);
    if (bottom && right && lr && lc) push_write(end_x, end_y, pix, fit, done);
    exp_writes_q[exp_writes_q.size()-1].last = 1'b1;
    if (lc) begin
      col_pos = '0;
      row_pos = lr ? '0 : CntW'(r + 1);
    end else begin
      col_pos = CntW'(c + 1);
    end
  endfunction

  // driver: one pixel transaction at a time from pixel_q
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      pixel    <= '0;
    end else begin
      if (in_valid && in_ready_o) predict_pixel(pixel);
      if (!in_valid || in_ready_o) begin
        if (pixel_q.size() != 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          pixel    <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each write transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        got_w = {dest_index_o, color_o, write_enable_o, fit_error_o, last_o, image_done_o};
        if (exp_writes_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected write: idx %h color %h we %b fit %b last %b done %b",
                     got_w.dest_index, got_w.color, got_w.write_enable, got_w.fit_error,
                     got_w.last, got_w.image_done);
          end
        end else begin
          want_w = exp_writes_q.pop_front();
          if (got_w !== want_w) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch exp: idx %h color %h we %b fit %b last %b done %b",
                       want_w.dest_index, want_w.color, want_w.write_enable,
                       want_w.fit_error, want_w.last, want_w.image_done);
              $display("         got: idx %h color %h we %b fit %b last %b done %b",
                       got_w.dest_index, got_w.color, got_w.write_enable, got_w.fit_error,
                       got_w.last, got_w.image_done);
            end
          end
        end
      end
      out_ready <= !idle_roll();
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("padded_blit_address_gen_core_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    case (idx)
      RegDstWidth:  dst_w_m = DimW'(val);
      RegDstHeight: dst_h_m = DimW'(val);
      RegPlaceX:    plc_x_m = PlaceW'(val);
      RegPlaceY:    plc_y_m = PlaceW'(val);
      RegSrcWidth:  src_w_m = DimW'(val);
      RegSrcHeight: src_h_m = DimW'(val);
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned dw, input int unsigned dh,
                           input int unsigned px, input int unsigned py,
                           input int unsigned sw, input int unsigned sh);
    write_reg(RegDstWidth, dw);
    write_reg(RegDstHeight, dh);
    write_reg(RegPlaceX, px);
    write_reg(RegPlaceY, py);
    write_reg(RegSrcWidth, sw);
    write_reg(RegSrcHeight, sh);
    cfg_done();
  endtask

  task automatic feed(input int unsigned n);
    repeat (n) pixel_q.push_back($urandom);
    sent_cnt += n;
  endtask

  // wait until every pixel is taken and every write has come back
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid || exp_writes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_dim();
    int unsigned k;
    k = $urandom_range(6);
    case (k)
      0: return 0;
      1: return 1;
      2: return 4095;
      3: return 4096;
      4: return 4097;
      5: return 8191;
      default: return $urandom_range(1, 8191);
    endcase
  endfunction

  task automatic random_phase();
    int unsigned dw, dh, px, py, sw, sh, esw, esh, n;
    if ($urandom_range(99) < 10) begin
      dw = pick_dim();
      dh = pick_dim();
      px = $urandom_range(1) ? 4095 : $urandom_range(0, 4095);
      py = $urandom_range(1) ? 0 : $urandom_range(0, 4095);
      sw = pick_dim();
      sh = pick_dim();
      configure(dw, dh, px, py, sw, sh);
      feed($urandom_range(1, 6));
    end else begin
      dw = $urandom_range(1, 20);
      dh = $urandom_range(1, 20);
      sw = $urandom_range(0, 6);
      sh = $urandom_range(0, 5);
      px = $urandom_range(0, dw);
      py = $urandom_range(0, dh);
      configure(dw, dh, px, py, sw, sh);
      esw = (sw == 0) ? 1 : sw;
      esh = (sh == 0) ? 1 : sh;
      n = esw * esh;
      // mostly whole images, sometimes a broken one that leaves the position mid-image
      if ($urandom_range(99) < 20) n = $urandom_range(1, n);
      feed(n);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: one pixel images into a one pixel destination
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'hFFFF_FFFF);
    sent_cnt += 2;
    drain();

    // all four sides and corners padded
    configure(8, 6, 2, 1, 3, 2);
    pixel_q.push_back(32'hAAAA_AAAA);
    pixel_q.push_back(32'h5555_5555);
    sent_cnt += 2;
    feed(4);
    drain();

    // placement that does not fit, writes beyond the edge suppressed
    configure(4, 4, 3, 3, 2, 2);
    feed(4);
    drain();

    // zero destination and zero source sizes
    configure(0, 0, 0, 0, 0, 0);
    feed(1);
    drain();

    // oversized source at the far corner of the largest destination
    configure(8191, 8191, 4095, 4095, 5000, 8191);
    feed(2);
    drain();

    // source width shrinks under a column already past the new last one
    configure(16, 16, 1, 1, 8, 4);
    feed(5);
    drain();
    write_reg(RegSrcWidth, 3);
    cfg_done();
    feed(2);
    drain();

    while (sent_cnt < NumItems) begin
      calm = (sent_cnt >= 120) && (sent_cnt < 180);
      random_phase();
    end
    calm = 1'b0;

    drain();
    if (exp_writes_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("padded_blit_address_gen_core_tb: PASS");
    end else begin
      $display("padded_blit_address_gen_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pbag_pkg.sv
rtl/core/pbag_front.sv
rtl/core/pbag_queue.sv
rtl/core/pbag_back.sv
rtl/core/padded_blit_address_gen_core.sv
tb/padded_blit_address_gen_core_tb.sv
